// File: rtl/fls_pkg.sv
// Package with the shared constants, codes and request types of the free-list slot allocator.
package fls_pkg;

  // Pool geometry and element width.
  localparam int unsigned CAPACITY   = 256;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned SLOT_W     = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);

  // Operation codes carried by an input item.
  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_READ    = 2'd2
  } op_e;

  // Status codes carried by a result item.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Access to the free-slot stack memory.
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [SLOT_W-1:0] wr_data;
  } stk_req_t;

  // Access to the element store memory.
  typedef struct packed {
    logic                  rd_en;
    logic [SLOT_W-1:0]     rd_addr;
    logic                  wr_en;
    logic [SLOT_W-1:0]     wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
  } sto_req_t;

endpackage

// File: rtl/fls_if.sv
// Valid/ready channel interfaces for operation items and result items.
interface fls_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  slot_number_in;
  logic [31:0] element_data;

  modport source (output valid, output opcode, output slot_number_in, output element_data,
                  input ready);
  modport sink (input valid, input opcode, input slot_number_in, input element_data,
                output ready);
endinterface

interface fls_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  slot_number_out;
  logic [31:0] read_data;
  logic [1:0]  status;
  logic [8:0]  free_slots;

  modport source (output valid, output slot_number_out, output read_data, output status,
                  output free_slots, input ready);
  modport sink (input valid, input slot_number_out, input read_data, input status,
                input free_slots, output ready);
endinterface

// File: rtl/free_list_slot_allocator.sv
// Free-list slot allocator: a pool of 256 slots of 32-bit elements, each operation item
// (allocate and store, release, read) gives one result item. The free slot numbers live in
// a last-in first-out stack memory and the elements in a second memory; both are read on
// the cycle an item is accepted and written back when the item completes, which waits
// until the output register is free or being taken; a new item is not accepted while one is
// in flight. The result sits in an output register, so the next item is accepted while a
// result still waits to be taken. After reset the block is ready at once: the stack seed
// comes from per-entry valid bits, with no clearing pass. Allocating from an empty pool or
// releasing into a full stack reports an error status and changes nothing; a double release
// is not detected. Reading a slot that was never written returns undefined data.
module free_list_slot_allocator
  import fls_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  fls_req_if.sink   req_i,
  fls_rsp_if.source rsp_o
);

  logic                  pend_q;
  logic [1:0]            op_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [DATA_WIDTH-1:0] elem_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  logic                  out_vld_q;
  logic [SLOT_W-1:0]     out_slot_q, out_slot_d;
  logic [DATA_WIDTH-1:0] out_data_q, out_data_d;
  status_e               out_st_q, out_st_d;
  logic [CNT_W-1:0]      out_cnt_q;

  logic                  accept;
  logic                  done;
  stk_req_t              stk_req;
  sto_req_t              sto_req;
  logic [SLOT_W-1:0]     stk_rd;
  logic [DATA_WIDTH-1:0] sto_rd;

  // One item in flight; it completes once the output register is free.
  assign req_i.ready = !pend_q;
  assign accept      = req_i.valid && !pend_q;
  assign done        = pend_q && (!out_vld_q || rsp_o.ready);

  // Item register and in-flight flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (accept) begin
      pend_q <= 1'b1;
    end else if (done) begin
      pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= req_i.opcode;
      slot_q <= req_i.slot_number_in;
      elem_q <= req_i.element_data;
    end
  end

  // Read-modify-write of the stack and store, with the result computed alongside.
  always_comb begin
    stk_req         = '0;
    sto_req         = '0;
    stk_req.rd_en   = accept;
    stk_req.rd_addr = SLOT_W'(cnt_q - CNT_W'(1));
    sto_req.rd_en   = accept;
    sto_req.rd_addr = req_i.slot_number_in;
    cnt_d           = cnt_q;
    out_slot_d      = slot_q;
    out_data_d      = '0;
    out_st_d        = ST_OK;
    case (op_q)
      OP_ALLOC: begin
        if (cnt_q == '0) begin
          out_st_d   = ST_EMPTY;
          out_slot_d = '0;
        end else begin
          out_slot_d      = stk_rd;
          cnt_d           = cnt_q - CNT_W'(1);
          sto_req.wr_en   = done;
          sto_req.wr_addr = stk_rd;
          sto_req.wr_data = elem_q;
        end
      end
      OP_RELEASE: begin
        if (cnt_q >= CNT_W'(CAPACITY)) begin
          out_st_d = ST_FULL;
        end else begin
          cnt_d           = cnt_q + CNT_W'(1);
          stk_req.wr_en   = done;
          stk_req.wr_addr = SLOT_W'(cnt_q);
          stk_req.wr_data = slot_q;
        end
      end
      OP_READ: begin
        out_data_d = sto_rd;
      end
      default: begin
      end
    endcase
  end

  // Free-slot count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CNT_W'(CAPACITY);
    end else if (done) begin
      cnt_q <= cnt_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (done) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_slot_q <= out_slot_d;
      out_data_q <= out_data_d;
      out_st_q   <= out_st_d;
      out_cnt_q  <= cnt_d;
    end
  end

  assign rsp_o.valid           = out_vld_q;
  assign rsp_o.slot_number_out = out_slot_q;
  assign rsp_o.read_data       = out_data_q;
  assign rsp_o.status          = out_st_q;
  assign rsp_o.free_slots      = out_cnt_q;

  // Memories.
  fls_stack u_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (stk_req),
    .rd_data_o (stk_rd)
  );

  fls_store u_store (
    .clk_i     (clk_i),
    .req_i     (sto_req),
    .rd_data_o (sto_rd)
  );

`ifndef SYNTHESIS
  // The free count never exceeds the pool size.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("free count above capacity");

  // The count only moves when an item completes.
  a_cnt_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> $past(done))
    else $error("free count changed without a completed item");

  // An empty-pool error is only reported with no free slot.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_st_q == ST_EMPTY) |-> (out_cnt_q == '0))
    else $error("empty status with free slots left");

  // A full-stack error is only reported with every slot free.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_st_q == ST_FULL) |-> (out_cnt_q == CNT_W'(CAPACITY)))
    else $error("full status with slots in use");
`endif

endmodule

// File: rtl/fls_stack.sv
// Free-slot stack memory with per-entry valid bits that stand in for the reset seed.
module fls_stack
  import fls_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stk_req_t          req_i,
  output logic [SLOT_W-1:0] rd_data_o
);

  logic [SLOT_W-1:0] mem [CAPACITY];
  logic [CAPACITY-1:0] vld_q;
  logic [SLOT_W-1:0] mem_rd_q;
  logic [SLOT_W-1:0] rd_addr_q;
  logic              rd_vld_q;

  // Memory array: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      mem_rd_q  <= mem[req_i.rd_addr];
      rd_addr_q <= req_i.rd_addr;
    end
  end

  // An entry holds its seed value until it is first written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  // The seed puts slot CAPACITY-1-i in entry i, so slot 0 pops first.
  assign rd_data_o = rd_vld_q ? mem_rd_q : (SLOT_W'(CAPACITY - 1) - rd_addr_q);

endmodule

// File: rtl/fls_store.sv
// Element store memory, one entry per slot.
module fls_store
  import fls_pkg::*;
(
  input  logic                  clk_i,
  input  sto_req_t              req_i,
  output logic [DATA_WIDTH-1:0] rd_data_o
);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_q;

  // Single write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule
